>>> rtl/moving_average_decline_detect_unit_assert.svh
// Assertion macros shared by the moving average decline detector RTL.
`ifndef MOVING_AVERAGE_DECLINE_DETECT_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_DECLINE_DETECT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MADA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MADA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mada_pkg.sv
// Shared constants and types of the moving average decline detector.
package mada_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_LEN_BITS = 5;
  localparam logic [CFG_LEN_BITS-1:0] WINDOW_LEN_RST = 5'd4;

  // Drops in a row that make the decline flag stick.
  localparam logic [1:0] DROPS_NEEDED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } mada_state_t;

endpackage

>>> rtl/moving_average_decline_detect_unit.sv
// Top level of the boxcar moving average with sticky decline detection.
//
//   Port group  | Direction | Payload
//   in_         | slave     | tdata: sample; tlast: last sample of the series
//   out_        | master    | tdata: average, declining; tuser: has_average;
//               |           | tlast: last result of the series
//   cfg_        | write     | wr_data: window length
//
// After a sample with a result the block takes no new sample until the
// shared bit-serial divider, which produces one quotient bit per cycle, has
// finished and the result has moved on to the output register.
// Reset is synchronous, active low; the window cells need no clearing pass.
// A result waiting in the output register does not block the next request;
// a finished division waits only if that register is still full.
module moving_average_decline_detect_unit #(
  parameter int WINDOW_MAX  = mada_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mada_pkg::SAMPLE_BITS_DEF,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DATA_W-1:0]           in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_DATA_W-1:0]          out_tdata,  // average, then declining
  output logic                           out_tuser,  // has_average
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [mada_pkg::CFG_LEN_BITS-1:0] cfg_wr_data  // window_len
);

  import mada_pkg::*;

  `include "moving_average_decline_detect_unit_assert.svh"

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int KW    = (LEN_W > CFG_LEN_BITS) ? LEN_W : CFG_LEN_BITS;
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

  mada_state_t state_r, state_nxt;

  logic [CFG_LEN_BITS-1:0] window_len_r;
  logic [KW-1:0]           active_r, fill_r;
  logic [SUM_W-1:0]        sum_r, prev_r;
  logic [1:0]              drop_r;
  logic                    decl_r;
  logic                    pend_has_r, pend_last_r, pend_decl_r;

  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_avg_r;
  logic                    out_has_r, out_decl_r, out_last_r;

  logic                    acc;
  logic [SAMPLE_BITS-1:0]  sample;
  logic [KW-1:0]           cfg_ext, cfg_eff, k_cur, fill_inc;
  logic                    had_full, full_now;
  logic [SUM_W-1:0]        sum_nxt;
  logic [1:0]              drop_nxt;
  logic                    decl_nxt;
  logic                    div_start, div_done;
  logic [SUM_W-1:0]        div_quot;
  logic                    emit;
  logic [SAMPLE_BITS-1:0]  tap_old;

  logic [SAMPLE_BITS-1:0]  cell_d   [WINDOW_MAX+1];
  logic [SAMPLE_BITS-1:0]  tap_link [WINDOW_MAX+1];

  assign sample = in_tdata[SAMPLE_BITS-1:0];
  assign acc    = in_tvalid && in_tready;

  // Clamp the programmed length to 1..WINDOW_MAX.
  assign cfg_ext = KW'(window_len_r);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_eff = KW'(1);
    end else if (cfg_ext > KW'(WINDOW_MAX)) begin
      cfg_eff = KW'(WINDOW_MAX);
    end else begin
      cfg_eff = cfg_ext;
    end
  end

  assign k_cur    = (fill_r == '0) ? cfg_eff : active_r;
  assign had_full = fill_r >= k_cur;
  assign fill_inc = had_full ? fill_r : fill_r + 1'b1;
  assign full_now = fill_inc >= k_cur;

  // Window shift line; cell 0 holds the newest sample.
  assign cell_d[0]   = sample;
  assign tap_link[0] = '0;
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    mada_cell #(
      .IDX         (i),
      .KW          (KW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (acc),
      .d_in     (cell_d[i]),
      .d_out    (cell_d[i+1]),
      .win_len  (k_cur),
      .tap_in   (tap_link[i]),
      .tap_out  (tap_link[i+1])
    );
  end
  assign tap_old = tap_link[WINDOW_MAX];

  assign sum_nxt = sum_r - (had_full ? SUM_W'(tap_old) : '0) + SUM_W'(sample);

  always_comb begin
    drop_nxt = drop_r;
    decl_nxt = decl_r;
    if (had_full) begin
      if (sum_nxt < prev_r) begin
        if (drop_r < DROPS_NEEDED) begin
          drop_nxt = drop_r + 1'b1;
        end
        if (drop_nxt >= DROPS_NEEDED) begin
          decl_nxt = 1'b1;
        end
      end else begin
        drop_nxt = '0;
      end
    end
  end

  assign div_start = acc && full_now;

  mada_divider #(
    .SUM_W (SUM_W),
    .KW    (KW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (k_cur),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next state and handshake.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (acc) begin
          if (full_now) begin
            state_nxt = S_DIV;
          end else if (in_tlast) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= WINDOW_LEN_RST;
      active_r     <= KW'(WINDOW_LEN_RST);
      fill_r       <= '0;
      sum_r        <= '0;
      prev_r       <= '0;
      drop_r       <= '0;
      decl_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        window_len_r <= cfg_wr_data;
      end
      if (acc) begin
        if (in_tlast) begin
          // Drop all series state after the last sample.
          fill_r <= '0;
          sum_r  <= '0;
          prev_r <= '0;
          drop_r <= '0;
          decl_r <= 1'b0;
        end else begin
          fill_r <= fill_inc;
          sum_r  <= sum_nxt;
          if (full_now) begin
            prev_r <= sum_nxt;
            drop_r <= drop_nxt;
            decl_r <= decl_nxt;
          end
        end
        if (fill_r == '0) begin
          active_r <= cfg_eff;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result fields held while the division runs.
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_has_r  <= full_now;
      pend_last_r <= in_tlast;
      pend_decl_r <= full_now ? decl_nxt : 1'b0;
    end
    if (emit) begin
      out_avg_r  <= pend_has_r ? div_quot[SAMPLE_BITS-1:0] : '0;
      out_has_r  <= pend_has_r;
      out_decl_r <= pend_decl_r;
      out_last_r <= pend_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_decl_r, out_avg_r});
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  `MADA_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV, "divider done outside division")
  `MADA_ASSERT_NOW(a_fill_le_len, fill_r != '0, fill_r <= active_r, "fill count beyond window")
  `MADA_ASSERT_NOW(a_drop_sticky, drop_r == DROPS_NEEDED, decl_r, "two drops without decline flag")
  `MADA_ASSERT_NOW(a_short_is_last, out_tvalid && !out_tuser, out_tlast && !out_tdata[SAMPLE_BITS],
                   "result without average not at series end")
  `MADA_ASSERT_NEXT(a_div_holds, state_r == S_DIV && !div_done, state_r == S_DIV,
                    "left division early")

endmodule

>>> rtl/mada_cell.sv
// One window cell: holds a sample, shifts it on, and taps it out when selected.
module mada_cell #(
  parameter int IDX         = 0,
  parameter int KW          = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [SAMPLE_BITS-1:0] d_in,
  output logic [SAMPLE_BITS-1:0] d_out,
  input  logic [KW-1:0]          win_len,
  input  logic [SAMPLE_BITS-1:0] tap_in,
  output logic [SAMPLE_BITS-1:0] tap_out
);

  logic [SAMPLE_BITS-1:0] data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

  // This cell holds the sample that drops out of a window of IDX+1 entries.
  assign tap_out = (win_len == KW'(IDX + 1)) ? data_r : tap_in;

endmodule

>>> rtl/mada_divider.sv
// Restoring divider, one quotient bit per cycle.
module mada_divider #(
  parameter int SUM_W = 20,
  parameter int KW    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [KW-1:0]    divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [KW-1:0]    rem_r, rem_nxt;
  logic [KW-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [KW:0]      trial;
  logic [KW:0]      diff;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt  = diff[KW-1:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[KW-1:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the moving average decline detector.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mada_pkg::*;

  localparam int IN_W          = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W         = ((SAMPLE_BITS_DEF + 1 + 7) / 8) * 8;
  localparam int SLOT_W        = $clog2(WINDOW_MAX_DEF);
  localparam int SUM_W         = SAMPLE_BITS_DEF + SLOT_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 130;
  localparam int NUM_PHASES    = 12;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] average;
    logic                       has_average;
    logic                       declining;
    logic                       last_res;
  } avg_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_t;

  typedef enum logic [1:0] {
    SHAPE_NOISE,
    SHAPE_FALL,
    SHAPE_RISE,
    SHAPE_EDGE
  } shape_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [SAMPLE_BITS_DEF-1:0] val;
    logic                       lst;
    logic                       typed;
    avg_result_t                res;
  } dir_row_t;

  localparam avg_result_t NO_RES    = '0;
  localparam avg_result_t SHORT_END = '{16'h0000, 1'b0, 1'b0, 1'b1};
  localparam int DIR_N = 26;

  // Directed requests: short series, extremes, decline, zero and oversized
  // window, window change in the middle of a series.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_SAMPLE, 16'h1234, 1'b1, 1'b1, SHORT_END},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, NO_RES},
    '{ROW_CFG,    16'd0,    1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b1}},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 1'b1, '{16'h0001, 1'b1, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, NO_RES},
    '{ROW_CFG,    16'd17,   1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0001, 1'b1, 1'b1, SHORT_END},
    '{ROW_CFG,    16'd2,    1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0100, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG,    16'd5,    1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0300, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0200, 1'b1, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0010, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0020, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0030, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0040, 1'b0, 1'b0, NO_RES},
    '{ROW_SAMPLE, 16'h0050, 1'b1, 1'b1, '{16'h0030, 1'b1, 1'b0, 1'b1}}
  };

  localparam logic [CFG_LEN_BITS-1:0] PHASE_WIN [NUM_PHASES] = '{
    5'd16, 5'd31, 5'd1, 5'd3, 5'd8, 5'd0, 5'd4, 5'd12, 5'd2, 5'd7, 5'd16, 5'd5
  };

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [IN_W-1:0]         in_tdata    = '0;
  logic                    in_tlast    = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic [OUT_W-1:0]        out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    cfg_wr_en   = 1'b0;
  logic [CFG_LEN_BITS-1:0] cfg_wr_data = '0;

  // Shadow copy of the block's series state.
  logic [SAMPLE_BITS_DEF-1:0] win_ring [WINDOW_MAX_DEF];
  logic [SLOT_W-1:0]          ring_slot;
  logic [SUM_W-1:0]           win_sum;
  logic [CFG_LEN_BITS-1:0]    fill_cnt;
  logic [SUM_W-1:0]           prev_sum;
  logic [1:0]                 drop_cnt;
  logic                       decline_flag;
  logic [CFG_LEN_BITS-1:0]    series_len;
  logic [CFG_LEN_BITS-1:0]    win_reg;

  avg_result_t avg_expected [$];
  int          err_cnt   = 0;
  int          cycle_cnt = 0;
  bit          calm      = 1'b0;
  bit          tx_steady = 1'b0;
  bit          hold_req  = 1'b0;

  moving_average_decline_detect_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [15:0] sample
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [15:0] average, [16] declining
    .out_tuser   (out_tuser),    // [0] has_average
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic logic [CFG_LEN_BITS-1:0] usable_len(input logic [CFG_LEN_BITS-1:0] v);
    if (v == 0) return CFG_LEN_BITS'(1);
    if (v > WINDOW_MAX_DEF) return CFG_LEN_BITS'(WINDOW_MAX_DEF);
    return v;
  endfunction

  function automatic void clear_series();
    ring_slot    = '0;
    win_sum      = '0;
    fill_cnt     = '0;
    prev_sum     = '0;
    drop_cnt     = '0;
    decline_flag = 1'b0;
    series_len   = usable_len(win_reg);
  endfunction

  // Advance the shadow state by one sample; return 1 when a result is due.
  function automatic bit predict_window(input logic [SAMPLE_BITS_DEF-1:0] smp,
                                        input bit lst, output avg_result_t r);
    logic [CFG_LEN_BITS-1:0] len;
    logic [SLOT_W-1:0]       old_slot;
    logic [SUM_W-1:0]        quot;
    bit                      was_full;
    bit                      got;
    if (fill_cnt == 0) series_len = usable_len(win_reg);
    len      = series_len;
    was_full = fill_cnt >= len;
    if (was_full) begin
      // a full window drops its oldest sample, len slots behind the write slot
      old_slot = ring_slot - len[SLOT_W-1:0];
      win_sum  = win_sum - SUM_W'(win_ring[old_slot]);
    end
    win_ring[ring_slot] = smp;
    ring_slot = ring_slot + 1'b1;
    win_sum   = win_sum + SUM_W'(smp);
    if (fill_cnt < len) fill_cnt = fill_cnt + 1'b1;
    r   = '0;
    got = 1'b0;
    if (fill_cnt >= len) begin
      if (was_full) begin
        if (win_sum < prev_sum) begin
          if (drop_cnt < DROPS_NEEDED) drop_cnt = drop_cnt + 1'b1;
          if (drop_cnt >= DROPS_NEEDED) decline_flag = 1'b1;
        end else begin
          drop_cnt = '0;
        end
      end
      prev_sum      = win_sum;
      quot          = win_sum / len;
      r.average     = quot[SAMPLE_BITS_DEF-1:0];
      r.has_average = 1'b1;
      r.declining   = decline_flag;
      r.last_res    = lst;
      got           = 1'b1;
    end else if (lst) begin
      r.last_res = 1'b1;
      got        = 1'b1;
    end
    if (lst) clear_series();
    return got;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got_v, exp_v);
    err_cnt++;
  endtask

  // Append one expected result at the tail of the queue.
  function automatic void queue_result(input avg_result_t r);
    avg_expected = {avg_expected, r};
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic offer_sample(input logic [SAMPLE_BITS_DEF-1:0] smp, input bit lst,
                              input bit typed, input avg_result_t typed_res);
    avg_result_t r;
    bit          got;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(smp);
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    got = predict_window(smp, lst, r);
    if (typed) queue_result(typed_res);
    else if (got) queue_result(r);
    if (!calm && !tx_steady && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Write the window length once the block has drained.
  task automatic set_window(input logic [CFG_LEN_BITS-1:0] v);
    in_tvalid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_reg = v;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    avg_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (avg_expected.size() == 0) begin
        report_mismatch("unexpected result, average", int'(out_tdata[15:0]), 0);
      end else begin
        exp_r = avg_expected.pop_front();
        if (out_tdata[15:0] !== exp_r.average)
          report_mismatch("average", int'(out_tdata[15:0]), int'(exp_r.average));
        if (out_tuser !== exp_r.has_average)
          report_mismatch("has_average", int'(out_tuser), int'(exp_r.has_average));
        if (out_tdata[16] !== exp_r.declining)
          report_mismatch("declining", int'(out_tdata[16]), int'(exp_r.declining));
        if (out_tlast !== exp_r.last_res)
          report_mismatch("last_res", int'(out_tlast), int'(exp_r.last_res));
      end
    end
  end

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 63) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int                         len;
    int                         sent;
    int                         k;
    int                         d;
    shape_t                     shape;
    logic [SAMPLE_BITS_DEF-1:0] level;
    logic [SAMPLE_BITS_DEF-1:0] smp;
    logic [CFG_LEN_BITS-1:0]    wsel;

    foreach (win_ring[i]) win_ring[i] = '0;
    win_reg = WINDOW_LEN_RST;
    clear_series();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG)
        set_window(DIR_ROWS[i].val[CFG_LEN_BITS-1:0]);
      else
        offer_sample(DIR_ROWS[i].val, DIR_ROWS[i].lst, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wsel = (ph == 9) ? CFG_LEN_BITS'($urandom_range(0, 31)) : PHASE_WIN[ph];
      set_window(wsel);
      calm      = (ph >= NUM_PHASES - 2);
      // window of one: every request yields a result, so the block backs up
      tx_steady = (ph == 2);
      if (ph == 2) hold_req = 1'b1;
      k    = usable_len(win_reg);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       len = (k > 1) ? $urandom_range(1, k - 1) : 1;
          1:       len = $urandom_range(1, 3);
          default: len = k + $urandom_range(0, 24);
        endcase
        shape = shape_t'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) shape = SHAPE_FALL;
        level = SAMPLE_BITS_DEF'($urandom);
        for (int n = 0; n < len; n++) begin
          case (shape)
            SHAPE_FALL: begin
              smp   = level;
              d     = $urandom_range(0, 16'h0800);
              level = (level > d) ? level - SAMPLE_BITS_DEF'(d) : '0;
            end
            SHAPE_RISE: begin
              smp   = level;
              d     = $urandom_range(0, 16'h0800);
              level = (int'(level) + d > 16'hFFFF) ? 16'hFFFF : level + SAMPLE_BITS_DEF'(d);
            end
            SHAPE_EDGE: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:    smp = SAMPLE_BITS_DEF'($urandom);
          endcase
          offer_sample(smp, n == len - 1, 1'b0, NO_RES);
          sent++;
        end
      end
      tx_steady = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
